FILE: sv/snge_pkg.sv
// Shared types, constants and the sine table helper for the sine note generator.
`default_nettype none

package snge_pkg;

	// Field and register widths fixed by the interface
	localparam int LEN_W       = 16;
	localparam int STEP_W      = 21;
	localparam int TUNING_W    = 16;
	localparam int SAMPLE_W    = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 21;

	// Defaults for the top-level parameters
	localparam int SINE_ENTRIES_DEF         = 256;
	localparam int PHASE_BITS_DEF           = 16;
	localparam int VOLUME_FRACTION_BITS_DEF = 20;

	// Register indexes on the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_LEN  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DECAY_START = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_NOTE_LEN    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_STEP = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_DECAY_STEP  = 3'd4;

	// Register values after reset
	localparam logic [LEN_W-1:0]  ATTACK_LEN_RST  = 16'd5;
	localparam logic [LEN_W-1:0]  DECAY_START_RST = 16'd12348;
	localparam logic [LEN_W-1:0]  NOTE_LEN_RST    = 16'd16758;
	localparam logic [STEP_W-1:0] ATTACK_STEP_RST = 21'd237772;
	localparam logic [STEP_W-1:0] DECAY_STEP_RST  = 21'd238;

	// Saturation limits of the output sample
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;

	// Quarter-wave series constants: pi/2 in Q30 and the Taylor divisors (2k)(2k+1)
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned TAYLOR_DIV [8] = '{
		64'd1, 64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
	};

	// Payload of one sample tick
	typedef struct packed {
		logic                start_req;
		logic [TUNING_W-1:0] tuning_word;
	} in_item_t;

	// Payload of one output sample
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       sounding;
	} out_item_t;

	// Load enables of the stages behind the envelope stage
	typedef struct packed {
		logic s2;
		logic s3;
		logic out;
	} stage_en_t;

	// Evaluate sin(x) for x in Q30 by an odd series up to x^15, scaled to 32767.
	// Used only to build the constant table at elaboration.
	function automatic logic [14:0] quarter_series(input longint unsigned x);
		longint unsigned x2;
		longint unsigned term;
		longint unsigned v;
		longint          sum;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		for (int k = 1; k <= 7; k++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[k];
			if (k % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		v = (longint'(sum) * 64'd32767) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[14:0];
	endfunction

endpackage

`default_nettype wire

FILE: sv/snge_stream_if.sv
// Valid/ready stream channel with a typed payload.
`default_nettype none

interface snge_stream_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

FILE: sv/sine_note_generator_with_envelope.sv
// Sine note generator with attack/hold/decay envelope: top level and stage control.
//
// Usage: each transfer on the tick channel is one sample tick. start_req = 1 begins
// a note with the given tuning_word; otherwise tuning_word is ignored. Every tick
// yields exactly one transfer on the audio channel: a signed 16-bit sample and a
// sounding flag, which is 0 (with a zero sample) once the note length is used up
// or when no note was started.
// Throughput: one tick per cycle while the audio sink does not stall. The note state
// (phase, count, volume) updates in the cycle of the transfer, so consecutive ticks
// need no gap. Pipeline: a taken tick passes the index stage, the registered table
// read and the multiply stage, then the output register with saturation, which
// drives the audio channel.
// Configuration: five registers on the write port (attack length, decay start,
// note length, attack step, decay step); write them only while no tick is in flight.
// Reset: note silent, phase, count and volume cleared, registers at defaults.
// Stall: when the audio sink holds ready low, the stages fill up behind the output
// register; tick.ready falls only when every stage holds a sample.
`default_nettype none

module sine_note_generator_with_envelope import snge_pkg::*; #(
	parameter int SINE_ENTRIES         = SINE_ENTRIES_DEF,
	parameter int PHASE_BITS           = PHASE_BITS_DEF,
	parameter int VOLUME_FRACTION_BITS = VOLUME_FRACTION_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	snge_stream_if.sink                 tick,
	snge_stream_if.source               audio
);

	localparam int IDX_W = $clog2(SINE_ENTRIES);

	logic                              v_s1_q, v_s2_q, v_s3_q, out_v_q;
	logic                              en0, en1;
	stage_en_t                         en;
	logic                              take;
	logic [IDX_W-1:0]                  idx_s1;
	logic [VOLUME_FRACTION_BITS:0]     vol_s1;
	logic                              sounding_s1;
	logic signed [SAMPLE_W-1:0]        rom_s2;
	logic signed [SAMPLE_W-1:0]        sample_q;
	logic                              sounding_q;

	// Advance a stage when it is empty or its successor advances
	always_comb begin
		en.out = !out_v_q || audio.ready;
		en.s3  = !v_s3_q || en.out;
		en.s2  = !v_s2_q || en.s3;
		en1    = en.s2;
		en0    = !v_s1_q || en1;
	end

	assign tick.ready = en0;
	assign take       = tick.valid && en0;

	// Track which stages hold a sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q  <= 1'b0;
			v_s2_q  <= 1'b0;
			v_s3_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en0) begin
				v_s1_q <= take;
			end
			if (en.s2) begin
				v_s2_q <= v_s1_q;
			end
			if (en.s3) begin
				v_s3_q <= v_s2_q;
			end
			if (en.out) begin
				out_v_q <= v_s3_q;
			end
		end
	end

	snge_env_core #(
		.SINE_ENTRIES         (SINE_ENTRIES),
		.PHASE_BITS           (PHASE_BITS),
		.VOLUME_FRACTION_BITS (VOLUME_FRACTION_BITS)
	) u_env (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.take        (take),
		.start_req   (tick.payload.start_req),
		.tuning_word (tick.payload.tuning_word),
		.idx_s1      (idx_s1),
		.vol_s1      (vol_s1),
		.sounding_s1 (sounding_s1)
	);

	snge_sine_rom #(
		.ENTRIES (SINE_ENTRIES)
	) u_rom (
		.clk  (clk),
		.en   (en.s2),
		.addr (idx_s1),
		.data (rom_s2)
	);

	snge_scale #(
		.VOLUME_FRACTION_BITS (VOLUME_FRACTION_BITS)
	) u_scale (
		.clk         (clk),
		.en          (en),
		.rom_s2      (rom_s2),
		.vol_s1      (vol_s1),
		.sounding_s1 (sounding_s1),
		.sample_q    (sample_q),
		.sounding_q  (sounding_q)
	);

	// Drive the audio channel from the output register
	assign audio.valid            = out_v_q;
	assign audio.payload.sample   = sample_q;
	assign audio.payload.sounding = sounding_q;

	a_silent_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !sounding_q |-> sample_q == '0)
		else $error("silent sample is not zero");

	a_stalled_stage_kept: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3_q && !en.out |=> v_s3_q)
		else $error("multiply stage lost a sample while stalled");

endmodule

`default_nettype wire

FILE: sv/snge_sine_rom.sv
// Constant full-wave sine table with a registered read port.
`default_nettype none

module snge_sine_rom import snge_pkg::*; #(
	parameter int ENTRIES = SINE_ENTRIES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [$clog2(ENTRIES)-1:0]  addr,
	output logic signed [SAMPLE_W-1:0]       data
);

	logic signed [SAMPLE_W-1:0] table_w [ENTRIES];

	// Build each entry from the quarter wave by its quadrant
	for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_entry
		localparam int unsigned U = 4 * gi;
		localparam int unsigned Q = U / ENTRIES;
		localparam int unsigned R = U % ENTRIES;
		localparam int unsigned A = (Q % 2 == 1) ? ENTRIES - R : R;
		localparam longint unsigned X = (HALF_PI_Q30 * longint'(A)) / ENTRIES;
		localparam logic [14:0] MAG = (A == 0) ? 15'd0 :
			(A >= ENTRIES) ? 15'h7FFF : quarter_series(X);
		localparam logic signed [SAMPLE_W-1:0] VAL = (Q >= 2) ?
			-$signed({1'b0, MAG}) : $signed({1'b0, MAG});
		assign table_w[gi] = VAL;
	end

	// Register the read; hold while the next stage stalls
	always_ff @(posedge clk) begin
		if (en) begin
			data <= table_w[addr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/snge_env_core.sv
// Note state, envelope update and phase accumulator; feeds the table index stage.
`default_nettype none

module snge_env_core import snge_pkg::*; #(
	parameter int SINE_ENTRIES         = SINE_ENTRIES_DEF,
	parameter int PHASE_BITS           = PHASE_BITS_DEF,
	parameter int VOLUME_FRACTION_BITS = VOLUME_FRACTION_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [CFG_INDEX_W-1:0]           cfg_index,
	input  wire logic [CFG_DATA_W-1:0]            cfg_data,
	input  wire logic                             take,
	input  wire logic                             start_req,
	input  wire logic [TUNING_W-1:0]              tuning_word,
	output logic [$clog2(SINE_ENTRIES)-1:0]       idx_s1,
	output logic [VOLUME_FRACTION_BITS:0]         vol_s1,
	output logic                                  sounding_s1
);

	localparam int VOL_W = VOLUME_FRACTION_BITS + 1;
	localparam int IDX_W = $clog2(SINE_ENTRIES);
	localparam int IPW   = PHASE_BITS + IDX_W + 1;
	localparam int SUM_W = ((VOL_W > STEP_W) ? VOL_W : STEP_W) + 1;
	localparam logic [VOL_W-1:0] VOL_PEAK = {1'b1, {VOLUME_FRACTION_BITS{1'b0}}};

	logic [LEN_W-1:0]      attack_len_q, decay_start_q, note_len_q;
	logic [STEP_W-1:0]     attack_step_q, decay_step_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [TUNING_W-1:0]   tuning_q;
	logic [LEN_W-1:0]      count_q;
	logic [VOL_W-1:0]      vol_q;
	logic                  active_q;

	logic [TUNING_W-1:0]   tuning_eff;
	logic [LEN_W-1:0]      count_eff;
	logic [VOL_W-1:0]      vol_eff;
	logic                  active_eff;
	logic                  silent;
	logic [SUM_W-1:0]      vol_sum;
	logic [VOL_W-1:0]      vol_new;
	logic [IPW-1:0]        idx_wide;
	logic [IDX_W-1:0]      idx;

	// Take configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_len_q  <= ATTACK_LEN_RST;
			decay_start_q <= DECAY_START_RST;
			note_len_q    <= NOTE_LEN_RST;
			attack_step_q <= ATTACK_STEP_RST;
			decay_step_q  <= DECAY_STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ATTACK_LEN:  attack_len_q  <= cfg_data[LEN_W-1:0];
				REG_DECAY_START: decay_start_q <= cfg_data[LEN_W-1:0];
				REG_NOTE_LEN:    note_len_q    <= cfg_data[LEN_W-1:0];
				REG_ATTACK_STEP: attack_step_q <= cfg_data[STEP_W-1:0];
				REG_DECAY_STEP:  decay_step_q  <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Apply a note start ahead of the envelope step
	always_comb begin
		tuning_eff = start_req ? tuning_word : tuning_q;
		count_eff  = start_req ? '0 : count_q;
		vol_eff    = start_req ? '0 : vol_q;
		active_eff = start_req | active_q;
		silent     = !active_eff || (count_eff >= note_len_q);
	end

	// Envelope: attack, decay, turn point, hold
	always_comb begin
		vol_sum = SUM_W'(vol_eff) + SUM_W'(attack_step_q);
		if (count_eff < attack_len_q) begin
			vol_new = (vol_sum > SUM_W'(VOL_PEAK)) ? VOL_PEAK : VOL_W'(vol_sum);
		end else if (count_eff > decay_start_q) begin
			if (SUM_W'(vol_eff) > SUM_W'(decay_step_q)) begin
				vol_new = VOL_W'(SUM_W'(vol_eff) - SUM_W'(decay_step_q));
			end else begin
				vol_new = '0;
			end
		end else if (count_eff != decay_start_q) begin
			vol_new = VOL_PEAK;
		end else begin
			vol_new = vol_eff;
		end
	end

	// Scale the phase to a table index
	always_comb begin
		idx_wide = (IPW'(phase_q) * IPW'(SINE_ENTRIES)) >> PHASE_BITS;
		if (idx_wide >= IPW'(SINE_ENTRIES)) begin
			idx = IDX_W'(SINE_ENTRIES - 1);
		end else begin
			idx = idx_wide[IDX_W-1:0];
		end
	end

	// Advance note state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			tuning_q <= '0;
			count_q  <= '0;
			vol_q    <= '0;
			active_q <= 1'b0;
		end else if (take) begin
			tuning_q <= tuning_eff;
			if (silent) begin
				active_q <= 1'b0;
				count_q  <= count_eff;
				vol_q    <= vol_eff;
			end else begin
				active_q <= 1'b1;
				count_q  <= count_eff + LEN_W'(1);
				vol_q    <= vol_new;
				phase_q  <= phase_q + PHASE_BITS'(tuning_eff);
			end
		end
	end

	// Stage 1: table index and gain for this sample
	always_ff @(posedge clk) begin
		if (take) begin
			idx_s1      <= idx;
			vol_s1      <= silent ? '0 : vol_new;
			sounding_s1 <= !silent;
		end
	end

	a_vol_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		vol_q <= VOL_PEAK)
		else $error("volume above peak");

	a_start_latches_tuning: assert property (@(posedge clk) disable iff (!arst_n)
		take && start_req |=> tuning_q == $past(tuning_word))
		else $error("tuning word not latched at note start");

endmodule

`default_nettype wire

FILE: sv/snge_scale.sv
// Gain multiply and saturation stages between the table read and the output register.
`default_nettype none

module snge_scale import snge_pkg::*; #(
	parameter int VOLUME_FRACTION_BITS = VOLUME_FRACTION_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire stage_en_t                     en,
	input  wire logic signed [SAMPLE_W-1:0]    rom_s2,
	input  wire logic [VOLUME_FRACTION_BITS:0] vol_s1,
	input  wire logic                          sounding_s1,
	output logic signed [SAMPLE_W-1:0]         sample_q,
	output logic                               sounding_q
);

	localparam int VOL_W  = VOLUME_FRACTION_BITS + 1;
	localparam int PROD_W = SAMPLE_W + VOL_W;
	localparam int SHR_W  = PROD_W - VOLUME_FRACTION_BITS;

	logic [VOL_W-1:0]    vol_s2;
	logic                sounding_s2;
	logic [SAMPLE_W-1:0] mag;
	logic [PROD_W-1:0]   prod_s3;
	logic                neg_s3;
	logic                sounding_s3;
	logic [SHR_W-1:0]    shifted;
	logic [SAMPLE_W-1:0] sat;

	// Stage 2: carry gain alongside the table read
	always_ff @(posedge clk) begin
		if (en.s2) begin
			vol_s2      <= vol_s1;
			sounding_s2 <= sounding_s1;
		end
	end

	// Stage 3: magnitude times gain
	assign mag = rom_s2[SAMPLE_W-1] ? SAMPLE_W'(-rom_s2) : SAMPLE_W'(rom_s2);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			prod_s3     <= PROD_W'(mag) * PROD_W'(vol_s2);
			neg_s3      <= rom_s2[SAMPLE_W-1];
			sounding_s3 <= sounding_s2;
		end
	end

	// Drop the fraction, restore the sign and saturate
	always_comb begin
		shifted = SHR_W'(prod_s3 >> VOLUME_FRACTION_BITS);
		if (neg_s3) begin
			sat = (shifted > SHR_W'(32768)) ? SAMPLE_MIN : SAMPLE_W'(-shifted);
		end else begin
			sat = (shifted > SHR_W'(SAMPLE_MAX)) ? SAMPLE_MAX : SAMPLE_W'(shifted);
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (en.out) begin
			sample_q   <= $signed(sat);
			sounding_q <= sounding_s3;
		end
	end

endmodule

`default_nettype wire

FILE: test/sine_note_generator_with_envelope_tb.sv
// Self-checking testbench for the sine note generator: directed table, then random notes.
`default_nettype none

module sine_note_generator_with_envelope_tb import snge_pkg::*;;

	localparam int RAND_ITEMS   = 1800;
	localparam int CALM_ITEMS   = 200;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int DIR_ROWS     = 38;

	// Indexes past the last register; writes to them must change nothing
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = 3'd7;

	localparam int unsigned VOL_PEAK = 1 << VOLUME_FRACTION_BITS_DEF;

	typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t                kind;
		logic [CFG_INDEX_W-1:0]   reg_sel;
		logic [CFG_DATA_W-1:0]    reg_value;
		in_item_t                 tick_in;
		bit                       known;
		out_item_t                result;
	} dir_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	snge_stream_if #(.payload_t(in_item_t))  tick_if ();
	snge_stream_if #(.payload_t(out_item_t)) audio_if ();

	sine_note_generator_with_envelope u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tick      (tick_if),
		.audio     (audio_if)
	);

	// Register copies kept by the predictor
	logic [LEN_W-1:0]  attack_len_q  = ATTACK_LEN_RST;
	logic [LEN_W-1:0]  decay_start_q = DECAY_START_RST;
	logic [LEN_W-1:0]  note_len_q    = NOTE_LEN_RST;
	logic [STEP_W-1:0] attack_step_q = ATTACK_STEP_RST;
	logic [STEP_W-1:0] decay_step_q  = DECAY_STEP_RST;

	// Note state kept by the predictor
	logic [PHASE_BITS_DEF-1:0] osc_phase   = '0;
	logic [TUNING_W-1:0]       note_tuning = '0;
	logic [LEN_W-1:0]          note_pos    = '0;
	int unsigned               env_level   = 0;
	bit                        note_on     = 1'b0;
	int                        sine_table [SINE_ENTRIES_DEF];

	out_item_t expected_audio [$];
	dir_row_t  directed_rows [DIR_ROWS];
	int        fail_count  = 0;
	int        cycle_count = 0;
	int        stall_left  = 0;
	bit        idle_on     = 1'b1;

	// Quarter-wave sine in Q30 by an odd series up to x^15, scaled to full amplitude
	function automatic int quarter_sine(input int unsigned a);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned v;
		longint          acc;
		if (a == 0) begin
			return 0;
		end
		if (a >= SINE_ENTRIES_DEF) begin
			return 32767;
		end
		x    = (HALF_PI_Q30 * 64'(a)) / 64'(SINE_ENTRIES_DEF);
		x2   = (x * x) >> 30;
		term = x;
		acc  = longint'(x);
		for (int k = 1; k <= 7; k++) begin
			term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		v = (64'(acc) * 64'd32767) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return int'(v);
	endfunction

	// Advance the note by one tick and return the sample it produces
	function automatic out_item_t next_sample(input in_item_t tick_in);
		out_item_t       r;
		int              wave;
		int unsigned     mag;
		longint unsigned scaled;
		int              level;
		r = '0;
		if (tick_in.start_req) begin
			note_tuning = tick_in.tuning_word;
			note_pos    = '0;
			env_level   = 0;
			note_on     = 1'b1;
		end
		// Silence once the note is over; the phase stays where it is
		if (!note_on || note_pos >= note_len_q) begin
			note_on = 1'b0;
			return r;
		end
		// Envelope: attack wins over decay, the turn sample keeps the level
		if (note_pos < attack_len_q) begin
			env_level = env_level + attack_step_q;
			if (env_level > VOL_PEAK) begin
				env_level = VOL_PEAK;
			end
		end else if (note_pos > decay_start_q) begin
			env_level = (env_level > decay_step_q) ? env_level - decay_step_q : 0;
		end else if (note_pos != decay_start_q) begin
			env_level = VOL_PEAK;
		end
		// Top byte of the phase picks the table entry; scale and saturate
		wave   = sine_table[osc_phase[PHASE_BITS_DEF-1 -: 8]];
		mag    = (wave < 0) ? -wave : wave;
		scaled = (64'(mag) * 64'(env_level)) >> VOLUME_FRACTION_BITS_DEF;
		if (wave < 0) begin
			level = (scaled > 64'd32768) ? -32768 : -int'(scaled);
		end else begin
			level = (scaled > 64'd32767) ? 32767 : int'(scaled);
		end
		r.sample   = level[SAMPLE_W-1:0];
		r.sounding = 1'b1;
		osc_phase  = osc_phase + note_tuning;
		note_pos   = note_pos + 1'b1;
		return r;
	endfunction

	function automatic dir_row_t tick_row(input logic st, input logic [TUNING_W-1:0] tw);
		dir_row_t r;
		r.kind                = ROW_TICK;
		r.reg_sel             = '0;
		r.reg_value           = '0;
		r.tick_in.start_req   = st;
		r.tick_in.tuning_word = tw;
		r.known               = 1'b0;
		r.result              = '0;
		return r;
	endfunction

	function automatic dir_row_t known_row(input logic st, input logic [TUNING_W-1:0] tw,
			input logic signed [SAMPLE_W-1:0] smp, input logic snd);
		dir_row_t r;
		r                 = tick_row(st, tw);
		r.known           = 1'b1;
		r.result.sample   = smp;
		r.result.sounding = snd;
		return r;
	endfunction

	function automatic dir_row_t reg_row(input logic [CFG_INDEX_W-1:0] sel,
			input logic [CFG_DATA_W-1:0] val);
		dir_row_t r;
		r           = tick_row(1'b0, '0);
		r.kind      = ROW_REG;
		r.reg_sel   = sel;
		r.reg_value = val;
		return r;
	endfunction

	function automatic logic [LEN_W-1:0] pick_len(input int unsigned typical_max);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return LEN_W'($urandom);
			default: return LEN_W'($urandom_range(0, typical_max));
		endcase
	endfunction

	function automatic logic [STEP_W-1:0] pick_step();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return STEP_W'(VOL_PEAK);
			2: return '1;
			3, 4: return STEP_W'($urandom);
			default: return STEP_W'($urandom_range(1, 40000));
		endcase
	endfunction

	// Write one register and mirror it; the enable is dropped by the next tick or gap
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] sel,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		@(posedge clk);
		case (sel)
			REG_ATTACK_LEN:  attack_len_q  = val[LEN_W-1:0];
			REG_DECAY_START: decay_start_q = val[LEN_W-1:0];
			REG_NOTE_LEN:    note_len_q    = val[LEN_W-1:0];
			REG_ATTACK_STEP: attack_step_q = val[STEP_W-1:0];
			REG_DECAY_STEP:  decay_step_q  = val[STEP_W-1:0];
			default: ;
		endcase
	endtask

	// Drive one tick until its transfer, then queue the sample it should give
	task automatic send_tick(input in_item_t tick_in, input bit known, input out_item_t result);
		out_item_t predicted;
		cfg_we          <= 1'b0;
		tick_if.valid   <= 1'b1;
		tick_if.payload <= tick_in;
		do @(posedge clk); while (!tick_if.ready);
		predicted = next_sample(tick_in);
		expected_audio.push_back(known ? result : predicted);
	endtask

	// Sometimes drop valid for a burst of cycles
	task automatic hold_off();
		if (idle_on && $urandom_range(0, 5) == 0) begin
			cfg_we        <= 1'b0;
			tick_if.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// Drop valid and wait for every queued sample to come out
	task automatic settle();
		tick_if.valid <= 1'b0;
		while (expected_audio.size() != 0) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Audio sink: ready, with stall bursts while idling is on
	initial begin
		audio_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left != 0) begin
				stall_left--;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				audio_if.ready <= 1'b0;
				stall_left = $urandom_range(1, 17) - 1;
			end else begin
				audio_if.ready <= 1'b1;
			end
		end
	end

	// Compare each audio transfer with the oldest expected sample
	always @(posedge clk) begin : check_audio
		out_item_t want;
		if (arst_n && audio_if.valid && audio_if.ready) begin
			if (expected_audio.size() == 0) begin
				$error("audio transfer with no sample expected: sample %0d, sounding %0b",
					audio_if.payload.sample, audio_if.payload.sounding);
				fail_count++;
			end else begin
				want = expected_audio.pop_front();
				if (audio_if.payload.sample !== want.sample) begin
					$error("sample: expected %0d, got %0d", want.sample, audio_if.payload.sample);
					fail_count++;
				end
				if (audio_if.payload.sounding !== want.sounding) begin
					$error("sounding: expected %0b, got %0b", want.sounding,
						audio_if.payload.sounding);
					fail_count++;
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int       rand_sent;
		int       phase_len;
		int       span;
		in_item_t tick_in;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		tick_if.valid   = 1'b0;
		tick_if.payload = '0;
		rand_sent       = 0;

		// Build the sine table from the quarter wave by quadrant
		for (int i = 0; i < SINE_ENTRIES_DEF; i++) begin
			int unsigned u;
			int unsigned q;
			int unsigned rem;
			int          s;
			u   = 4 * i;
			q   = u / SINE_ENTRIES_DEF;
			rem = u % SINE_ENTRIES_DEF;
			s   = quarter_sine((q & 1) ? SINE_ENTRIES_DEF - rem : rem);
			sine_table[i] = (q >= 2) ? -s : s;
		end

		directed_rows = '{
			// silent after reset, then a note from phase zero at default settings
			known_row(1'b0, 16'hFFFF, 16'sd0, 1'b0),
			known_row(1'b1, 16'h4000, 16'sd0, 1'b1),
			tick_row(1'b0, 16'h0000),
			tick_row(1'b0, 16'h1234),
			tick_row(1'b0, 16'hFFFF),
			tick_row(1'b0, 16'h8000),
			tick_row(1'b0, 16'h0000),
			// restart while sounding keeps the phase
			tick_row(1'b1, 16'hFFFF),
			// zero note length is silent at once
			reg_row(REG_NOTE_LEN, 21'd0),
			known_row(1'b1, 16'hFFFF, 16'sd0, 1'b0),
			// attack overlapping decay, steps at their maximum, unused indexes
			reg_row(REG_ATTACK_LEN, 21'd2),
			reg_row(REG_DECAY_START, 21'd0),
			reg_row(REG_NOTE_LEN, 21'd4),
			reg_row(REG_ATTACK_STEP, 21'h1FFFFF),
			reg_row(REG_DECAY_STEP, 21'h1FFFFF),
			reg_row(REG_UNUSED_LO, 21'h1FFFFF),
			reg_row(REG_UNUSED_HI, 21'd0),
			tick_row(1'b1, 16'h4000),
			tick_row(1'b0, 16'h5555),
			known_row(1'b0, 16'hAAAA, 16'sd0, 1'b1),
			known_row(1'b0, 16'h0000, 16'sd0, 1'b1),
			known_row(1'b0, 16'h0000, 16'sd0, 1'b0),
			// short attack below peak, hold at peak, turn sample, decay by zero
			reg_row(REG_ATTACK_LEN, 21'd1),
			reg_row(REG_DECAY_START, 21'd2),
			reg_row(REG_NOTE_LEN, 21'hFFFF),
			reg_row(REG_ATTACK_STEP, 21'd1),
			reg_row(REG_DECAY_STEP, 21'd0),
			tick_row(1'b1, 16'h0040),
			tick_row(1'b0, 16'h0000),
			tick_row(1'b0, 16'h0000),
			tick_row(1'b0, 16'h0000),
			tick_row(1'b0, 16'h0000),
			// no attack, no decay: straight to peak
			reg_row(REG_ATTACK_LEN, 21'd0),
			reg_row(REG_DECAY_START, 21'hFFFF),
			reg_row(REG_ATTACK_STEP, 21'd0),
			tick_row(1'b1, 16'h0100),
			tick_row(1'b0, 16'h0000),
			tick_row(1'b0, 16'h0000)
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed table
		for (int r = 0; r < DIR_ROWS; r++) begin
			if (directed_rows[r].kind == ROW_REG) begin
				settle();
				write_reg(directed_rows[r].reg_sel, directed_rows[r].reg_value);
			end else begin
				hold_off();
				send_tick(directed_rows[r].tick_in, directed_rows[r].known,
					directed_rows[r].result);
			end
		end

		// Random phases: new settings, then notes with random tuning
		while (rand_sent < RAND_ITEMS) begin
			settle();
			write_reg(REG_ATTACK_LEN, CFG_DATA_W'(pick_len(30)));
			write_reg(REG_DECAY_START, CFG_DATA_W'(pick_len(80)));
			write_reg(REG_NOTE_LEN, CFG_DATA_W'(pick_len(150)));
			write_reg(REG_ATTACK_STEP, CFG_DATA_W'(pick_step()));
			write_reg(REG_DECAY_STEP, CFG_DATA_W'(pick_step()));
			if ($urandom_range(0, 2) == 0) begin
				write_reg(REG_UNUSED_LO + CFG_INDEX_W'($urandom_range(0, 2)),
					CFG_DATA_W'($urandom));
			end
			idle_on   = ($urandom_range(0, 3) != 0);
			phase_len = $urandom_range(40, 160);
			for (int n = 0; n < phase_len && rand_sent < RAND_ITEMS; n++) begin
				if (rand_sent + CALM_ITEMS >= RAND_ITEMS) begin
					idle_on = 1'b0;
				end
				// Mostly let notes play out, with a few restarts and silent stretches
				span = (note_len_q < 16'd200) ? int'(note_len_q) + 8 : 60;
				tick_in.start_req   = (n == 0) || ($urandom_range(0, span) == 0);
				tick_in.tuning_word = TUNING_W'($urandom);
				hold_off();
				send_tick(tick_in, 1'b0, '0);
				rand_sent++;
			end
		end

		// Drain and watch for stray transfers
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_audio.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
sv/snge_pkg.sv
sv/snge_stream_if.sv
sv/snge_sine_rom.sv
sv/snge_env_core.sv
sv/snge_scale.sv
sv/sine_note_generator_with_envelope.sv
test/sine_note_generator_with_envelope_tb.sv
